[design/far_pkg.sv]
// shared types and constants for the fraction arithmetic reduce block
package far_pkg;

	localparam int OPERAND_WIDTH_DEF = 32;
	localparam int MAG_W = 64;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_EQ  = 3'd4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_ZDEN    = 2'd1;
	localparam logic [1:0] ST_DIVZERO = 2'd2;
	localparam logic [1:0] ST_BAD     = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL1,
		S_MUL2,
		S_COMB,
		S_GCD_START,
		S_GCD_RUN,
		S_DIVN_START,
		S_DIVN_RUN,
		S_DIVD_START,
		S_DIVD_RUN,
		S_FINISH,
		S_OUT
	} far_state_t;

	// divider source selection
	typedef enum logic [1:0] {
		DSRC_GCD,
		DSRC_NUM,
		DSRC_DEN
	} far_dsrc_t;

	typedef struct packed {
		logic       load;
		logic       mul1;
		logic       mul2;
		logic       comb;
		logic       div_start;
		far_dsrc_t  div_src;
		logic       gcd_step;
		logic       take_num;
		logic       take_den;
		logic       finish;
	} far_cmd_t;

	typedef struct packed {
		logic       early;
		logic       div_done;
		logic       gcd_zero;
	} far_status_t;

endpackage

[design/fraction_arithmetic_reduce.sv]
// top level of the fraction arithmetic reduce block
// usage:
//   input channel: op, a_num, a_den, b_num, b_den with in_valid / in_stall;
//   a transfer happens on a clock edge with in_valid high and in_stall low
//   output channel: res_num, res_den, equal, status with out_valid / out_stall
//   one result per input item, in order
// sequence, input transfer to result transfer:
//   error and equality items go from the product steps straight to finish;
//   arithmetic items run one or more gcd remainder steps, then divide the
//   numerator and the denominator by the gcd; every such pass runs on the
//   shared bit-serial divider (one quotient bit a cycle)
// throughput: one item at a time; in_stall stays high from accept until
//   the result is transferred, the next input transfer can come in the next cycle
// reset: arst_n clears the controller to idle with no result pending
// stall: the result holds on its ports while out_stall is high
module fraction_arithmetic_reduce
	import far_pkg::*;
#(
	parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  op,
	input  logic [31:0] a_num,
	input  logic [31:0] a_den,
	input  logic [31:0] b_num,
	input  logic [31:0] b_den,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] res_num,
	output logic [61:0] res_den,
	output logic        equal,
	output logic [1:0]  status
);

	// command and status between controller and datapath
	far_cmd_t    cmd;
	far_status_t stat;

	far_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	far_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.stat    (stat),
		.op      (op),
		.a_num   (a_num),
		.a_den   (a_den),
		.b_num   (b_num),
		.b_den   (b_den),
		.res_num (res_num),
		.res_den (res_den),
		.equal   (equal),
		.status  (status)
	);

endmodule

[design/far_divider.sv]
// radix-2 restoring divider for 64-bit unsigned operands, one bit a cycle
module far_divider
	import far_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [MAG_W-1:0]  dividend,
	input  logic [MAG_W-1:0]  divisor,
	output logic              done,
	output logic [MAG_W-1:0]  quotient,
	output logic [MAG_W-1:0]  remainder
);

	localparam int CNT_W = $clog2(MAG_W + 1);

	logic [MAG_W-1:0] quo_q;
	logic [MAG_W-1:0] rem_q;
	logic [MAG_W-1:0] dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [MAG_W:0]   trial;
	logic [MAG_W:0]   shifted;

	always_comb begin
		shifted = {rem_q, quo_q[MAG_W-1]};
		trial   = shifted - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(MAG_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[MAG_W]) begin
				rem_q <= trial[MAG_W-1:0];
				quo_q <= {quo_q[MAG_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[MAG_W-1:0];
				quo_q <= {quo_q[MAG_W-2:0], 1'b0};
			end
		end
	end

	assign done      = !busy_q && !start;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

[design/far_datapath.sv]
// operand registers, cross products, gcd and reduction datapath
module far_datapath
	import far_pkg::*;
#(
	parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  far_cmd_t    cmd,
	output far_status_t stat,
	input  logic [2:0]  op,
	input  logic [31:0] a_num,
	input  logic [31:0] a_den,
	input  logic [31:0] b_num,
	input  logic [31:0] b_den,
	output logic [63:0] res_num,
	output logic [61:0] res_den,
	output logic        equal,
	output logic [1:0]  status
);

	localparam int W = OPERAND_WIDTH;
	localparam logic [MAG_W-1:0] NUM_LIMIT = {1'b0, {(MAG_W-1){1'b1}}};
	localparam logic [MAG_W-1:0] DEN_LIMIT = {2'b00, {(MAG_W-2){1'b1}}};

	logic [2:0]       op_q;
	logic [W-1:0]     an_q, ad_q, bn_q, bd_q;
	logic             early_q;
	logic [1:0]       st_q;
	logic [MAG_W-1:0] p1_q, p2_q;
	logic             n1_q, n2_q;
	logic [MAG_W-1:0] nm_q, dm_q;
	logic             nn_q, dn_q;
	logic [MAG_W-1:0] gx_q, gy_q;
	logic [63:0]      rnum_q;
	logic [61:0]      rden_q;
	logic             req_q;
	logic [1:0]       rst_q;

	// magnitudes and signs of the operands
	logic [W-1:0] ma_n, ma_d, mb_n, mb_d;
	logic         sa_n, sa_d, sb_n, sb_d;
	logic [W-1:0] m_x1, m_y1, m_x2, m_y2;
	logic         s_x1, s_y1, s_x2, s_y2;
	logic [MAG_W-1:0] prod1, prod2;
	logic [MAG_W-1:0] sum_mag;
	logic         sum_neg, n2_eff;
	logic [MAG_W-1:0] div_a, div_b, quo, rem;
	logic         div_done;

	function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
		return v[W-1] ? (~v + 1'b1) : v;
	endfunction

	always_comb begin
		sa_n = an_q[W-1]; sa_d = ad_q[W-1]; sb_n = bn_q[W-1]; sb_d = bd_q[W-1];
		ma_n = mag_of(an_q); ma_d = mag_of(ad_q);
		mb_n = mag_of(bn_q); mb_d = mag_of(bd_q);
		// first step: numerator product set
		m_x1 = ma_n; s_x1 = sa_n; m_y1 = mb_d; s_y1 = sb_d;
		m_x2 = mb_n; s_x2 = sb_n; m_y2 = ma_d; s_y2 = sa_d;
		if (op_q == OP_MUL) begin
			m_y1 = mb_n; s_y1 = sb_n;
		end
		// second step: denominator product
		if (cmd.mul2) begin
			m_x1 = ma_d; s_x1 = sa_d;
			m_y1 = (op_q == OP_DIV) ? mb_n : mb_d;
			s_y1 = (op_q == OP_DIV) ? sb_n : sb_d;
		end
		prod1 = MAG_W'(m_x1) * MAG_W'(m_y1);
		prod2 = MAG_W'(m_x2) * MAG_W'(m_y2);
	end

	always_comb begin
		n2_eff = (op_q == OP_SUB && p2_q != '0) ? !n2_q : n2_q;
		if (n1_q == n2_eff) begin
			sum_mag = p1_q + p2_q; sum_neg = n1_q;
		end else if (p1_q >= p2_q) begin
			sum_mag = p1_q - p2_q; sum_neg = n1_q;
		end else begin
			sum_mag = p2_q - p1_q; sum_neg = n2_eff;
		end
		if (sum_mag == '0) sum_neg = 1'b0;
	end

	always_comb begin
		case (cmd.div_src)
			DSRC_NUM: begin div_a = nm_q; div_b = gx_q; end
			DSRC_DEN: begin div_a = dm_q; div_b = gx_q; end
			default:  begin div_a = gx_q; div_b = gy_q; end
		endcase
	end

	far_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_a),
		.divisor   (div_b),
		.done      (div_done),
		.quotient  (quo),
		.remainder (rem)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op;
			an_q <= a_num[W-1:0]; ad_q <= a_den[W-1:0];
			bn_q <= b_num[W-1:0]; bd_q <= b_den[W-1:0];
		end
		if (cmd.mul1) begin
			p1_q <= prod1;
			n1_q <= (prod1 != '0) && (s_x1 != s_y1);
			p2_q <= prod2;
			n2_q <= (prod2 != '0) && (s_x2 != s_y2);
		end
		if (cmd.mul2) begin
			dm_q <= prod1;
			dn_q <= (prod1 != '0) && (s_x1 != s_y1);
		end
		if (cmd.comb) begin
			if (op_q <= OP_SUB) begin
				nm_q <= sum_mag; nn_q <= sum_neg;
				gx_q <= sum_mag;
			end else begin
				nm_q <= p1_q; nn_q <= n1_q;
				gx_q <= p1_q;
			end
			gy_q <= dm_q;
		end
		if (cmd.gcd_step) begin
			gx_q <= gy_q;
			gy_q <= rem;
		end
		if (cmd.take_num) nm_q <= quo;
		if (cmd.take_den) dm_q <= quo;
		if (cmd.finish) begin
			if (early_q) begin
				rnum_q <= '0; rden_q <= '0;
				req_q  <= (st_q == ST_OK) && (op_q == OP_EQ) && (p1_q == p2_q)
				          && (n1_q == n2_q);
				rst_q  <= st_q;
			end else if (nm_q > NUM_LIMIT || dm_q > DEN_LIMIT) begin
				rnum_q <= '0; rden_q <= '0; req_q <= 1'b0; rst_q <= ST_BAD;
			end else begin
				rnum_q <= (nm_q != '0 && nn_q != dn_q) ? (~nm_q + 1'b1) : nm_q;
				rden_q <= dm_q[61:0];
				req_q  <= 1'b0;
				rst_q  <= ST_OK;
			end
		end
	end

	// special cases are decided on the operands right after load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			early_q <= 1'b0;
			st_q    <= ST_OK;
		end else if (cmd.mul1) begin
			early_q <= 1'b1;
			if (ad_q == '0 || bd_q == '0)     st_q <= ST_ZDEN;
			else if (op_q > OP_EQ)            st_q <= ST_BAD;
			else if (op_q == OP_EQ)           st_q <= ST_OK;
			else if (op_q == OP_DIV && bn_q == '0) st_q <= ST_DIVZERO;
			else begin
				early_q <= 1'b0;
				st_q    <= ST_OK;
			end
		end
	end

	assign stat.early    = early_q;
	assign stat.div_done = div_done;
	assign stat.gcd_zero = (gy_q == '0);

	assign res_num = rnum_q;
	assign res_den = rden_q;
	assign equal   = req_q;
	assign status  = rst_q;

endmodule

[design/far_ctrl.sv]
// sequencing state machine for the fraction arithmetic reduce block
module far_ctrl
	import far_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	output logic        out_valid,
	input  logic        out_stall,
	output far_cmd_t    cmd,
	input  far_status_t stat
);

	far_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		cmd.div_src = DSRC_GCD;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_MUL1;
				end
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = stat.early ? S_FINISH : S_COMB;
			end
			S_COMB: begin
				cmd.comb = 1'b1;
				state_d  = S_GCD_START;
			end
			S_GCD_START: begin
				if (stat.gcd_zero) begin
					state_d = S_DIVN_START;
				end else begin
					cmd.div_start = 1'b1;
					state_d = S_GCD_RUN;
				end
			end
			S_GCD_RUN: begin
				if (stat.div_done) begin
					cmd.gcd_step = 1'b1;
					state_d = S_GCD_START;
				end
			end
			S_DIVN_START: begin
				cmd.div_src   = DSRC_NUM;
				cmd.div_start = 1'b1;
				state_d = S_DIVN_RUN;
			end
			S_DIVN_RUN: begin
				if (stat.div_done) begin
					cmd.take_num = 1'b1;
					state_d = S_DIVD_START;
				end
			end
			S_DIVD_START: begin
				cmd.div_src   = DSRC_DEN;
				cmd.div_start = 1'b1;
				state_d = S_DIVD_RUN;
			end
			S_DIVD_RUN: begin
				if (stat.div_done) begin
					cmd.take_den = 1'b1;
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				cmd.finish = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == S_MUL1)
		else $error("load not followed by product step");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid)
		else $error("finish without result");

endmodule

[bench/tb_fraction_arithmetic_reduce.sv]
// testbench for the fraction arithmetic reduce block: random and corner items vs a predictor
module tb_fraction_arithmetic_reduce;
	import far_pkg::*;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] a_num;
		logic [31:0] a_den;
		logic [31:0] b_num;
		logic [31:0] b_den;
	} frac_req_t;

	typedef struct packed {
		logic [63:0] res_num;
		logic [61:0] res_den;
		logic        equal;
		logic [1:0]  status;
	} frac_res_t;

	localparam int WATCHDOG_LIMIT = 200000;
	localparam int HOLD_CYCLES = 8000;
	localparam int DRAIN_CYCLES = 40;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  op = OP_ADD;
	logic [31:0] a_num = '0;
	logic [31:0] a_den = '0;
	logic [31:0] b_num = '0;
	logic [31:0] b_den = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] res_num;
	logic [61:0] res_den;
	logic        equal;
	logic [1:0]  status;

	frac_req_t pending_reqs[$];
	frac_res_t expected_results[$];
	int        fail_count = 0;
	int        idle_cycles = 0;
	// idling mode: 0 none, 1 sender idles, 2 receiver stalls, 3 both
	int        idle_mode = 0;
	bit        hold_receiver = 1'b0;

	// stall as seen at the last rising edge, so the driver knows a transfer took place
	logic in_stall_seen = 1'b1;

	always #2 clk = ~clk;

	fraction_arithmetic_reduce u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
		.out_valid(out_valid), .out_stall(out_stall),
		.res_num(res_num), .res_den(res_den), .equal(equal), .status(status)
	);

	// euclid on unsigned 64-bit magnitudes
	function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
		logic [63:0] r;
		while (y != 0) begin
			r = x % y;
			x = y;
			y = r;
		end
		return x;
	endfunction

	// exact rational result, worked in signed 128-bit arithmetic
	function automatic frac_res_t reduce_fraction(frac_req_t q);
		frac_res_t   r;
		logic signed [127:0] an, ad, bn, bd, num, den;
		logic [63:0] nm, dm, g;
		logic        neg;
		r = '0;
		an = 128'($signed(q.a_num));
		ad = 128'($signed(q.a_den));
		bn = 128'($signed(q.b_num));
		bd = 128'($signed(q.b_den));
		if (ad == 0 || bd == 0) begin
			r.status = ST_ZDEN;
			return r;
		end
		if (q.op > OP_EQ) begin
			r.status = ST_BAD;
			return r;
		end
		if (q.op == OP_EQ) begin
			r.equal = (an * bd == bn * ad);
			r.status = ST_OK;
			return r;
		end
		if (q.op == OP_DIV && bn == 0) begin
			r.status = ST_DIVZERO;
			return r;
		end
		case (q.op)
			OP_ADD: begin
				num = an * bd + bn * ad;
				den = ad * bd;
			end
			OP_SUB: begin
				num = an * bd - bn * ad;
				den = ad * bd;
			end
			OP_MUL: begin
				num = an * bn;
				den = ad * bd;
			end
			default: begin
				num = an * bd;
				den = ad * bn;
			end
		endcase
		neg = (num != 0) && ((num < 0) != (den < 0));
		nm = (num < 0) ? 64'(-num) : 64'(num);
		dm = (den < 0) ? 64'(-den) : 64'(den);
		g = gcd64(nm, dm);
		nm = nm / g;
		dm = dm / g;
		if (nm > 64'h7FFF_FFFF_FFFF_FFFF || dm > 64'h3FFF_FFFF_FFFF_FFFF) begin
			r.status = ST_BAD;
			return r;
		end
		r.res_num = neg ? (~nm + 64'd1) : nm;
		r.res_den = dm[61:0];
		r.status = ST_OK;
		return r;
	endfunction

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'($signed($urandom_range(0, 16)) - 8);
			3: return 32'($urandom_range(0, 1000));
			4: return 32'h8000_0000 + 32'($urandom_range(0, 3));
			5: return '0;
			default: return $urandom();
		endcase
	endfunction

	// one random idle draw: 67 in a hundred for a single side, 11 when both idle
	function automatic bit idle_roll();
		return $urandom_range(0, 99) < ((idle_mode == 3) ? 11 : 67);
	endfunction

	task automatic queue_req(logic [2:0] o, logic [31:0] an, logic [31:0] ad,
			logic [31:0] bn, logic [31:0] bd);
		frac_req_t q;
		q = '{op: o, a_num: an, a_den: ad, b_num: bn, b_den: bd};
		pending_reqs.push_back(q);
	endtask

	// driver: offers the head of the queue, changes only at falling edges
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall_seen) begin
				void'(pending_reqs.pop_front());
			end
			// a stalled offer keeps valid and payload as they are
			if (!(in_valid && in_stall_seen)) begin
				if (pending_reqs.size() > 0 && !(idle_mode[0] && idle_roll())) begin
					in_valid <= 1'b1;
					op <= pending_reqs[0].op;
					a_num <= pending_reqs[0].a_num;
					a_den <= pending_reqs[0].a_den;
					b_num <= pending_reqs[0].b_num;
					b_den <= pending_reqs[0].b_den;
				end else begin
					in_valid <= 1'b0;
				end
			end
			// receiver side stall, a long hold wins over the random mode
			out_stall <= hold_receiver || (idle_mode[1] && idle_roll());
		end
	end

	// monitor: samples at the rising edge, predicts on input transfer, checks on output transfer
	always @(posedge clk) begin
		frac_res_t want;
		bit        moved;
		moved = 1'b0;
		in_stall_seen <= !(in_valid && !in_stall);
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_results.push_back(reduce_fraction('{op: op, a_num: a_num,
					a_den: a_den, b_num: b_num, b_den: b_den}));
				moved = 1'b1;
			end
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				if (expected_results.size() == 0) begin
					$error("result transfer with nothing expected");
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (res_num !== want.res_num) begin
						$error("res_num expected %0d got %0d",
							$signed(want.res_num), $signed(res_num));
						fail_count++;
					end
					if (res_den !== want.res_den) begin
						$error("res_den expected %0d got %0d", want.res_den, res_den);
						fail_count++;
					end
					if (equal !== want.equal) begin
						$error("equal expected %0b got %0b", want.equal, equal);
						fail_count++;
					end
					if (status !== want.status) begin
						$error("status expected %0d got %0d", want.status, status);
						fail_count++;
					end
				end
			end
			idle_cycles <= moved ? 0 : idle_cycles + 1;
		end
	end

	// watchdog on cycles with no transfer at all
	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// long receiver hold-off while the sender keeps offering items
	initial begin
		wait (arst_n);
		repeat (2000) @(posedge clk);
		hold_receiver = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_receiver = 1'b0;
	end

	initial begin
		logic [2:0] o;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: every op, extremes, zero denominators, divide by zero fraction
		for (int k = 0; k < 5; k++) begin
			queue_req(3'(k), 32'd1, 32'd2, 32'd1, 32'd3);
		end
		queue_req(OP_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		queue_req(OP_MUL, 32'h8000_0000, 32'h1, 32'h8000_0000, 32'h1);
		queue_req(OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h1, 32'h8000_0000);
		queue_req(OP_SUB, 32'h7FFF_FFFF, 32'h8000_0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		queue_req(OP_SUB, 32'd5, 32'd7, 32'd5, 32'd7);
		queue_req(OP_ADD, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd9);
		queue_req(OP_ADD, 32'd1, 32'd0, 32'd1, 32'd1);
		queue_req(OP_EQ, 32'd1, 32'd1, 32'd1, 32'd0);
		queue_req(OP_DIV, 32'd3, 32'd4, 32'd0, 32'd5);
		queue_req(OP_EQ, 32'd2, 32'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
		queue_req(OP_EQ, 32'd2, 32'd4, 32'd1, 32'd3);
		queue_req(OP_MUL, 32'hFFFF_FFFF, 32'd3, 32'd6, 32'hFFFF_FFFE);
		queue_req(3'd5, 32'd1, 32'd1, 32'd1, 32'd1);
		queue_req(3'd7, 32'd1, 32'd1, 32'd1, 32'd1);
		queue_req(OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);

		// random, cycling through the idling modes
		for (int n = 0; n < 500; n++) begin
			o = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
				: 3'($urandom_range(0, 4));
			queue_req(o, rand_operand(), rand_operand(), rand_operand(), rand_operand());
		end
		for (int ph = 0; ph < 5; ph++) begin
			idle_mode = ph % 4;
			wait (pending_reqs.size() <= 400 - ph * 100 || pending_reqs.size() == 0);
		end
		idle_mode = 3;
		wait (pending_reqs.size() == 0 && !in_valid);
		wait (expected_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

[fraction_arithmetic_reduce.f]
design/far_pkg.sv
design/far_divider.sv
design/far_datapath.sv
design/far_ctrl.sv
design/fraction_arithmetic_reduce.sv
bench/tb_fraction_arithmetic_reduce.sv
